/* hdl/xoshiro256ss_prng_with_seeding_top_macros.svh */
// Assertion macros used by the generator core.
`ifndef XOSHIRO256SS_PRNG_WITH_SEEDING_TOP_MACROS_SVH
`define XOSHIRO256SS_PRNG_WITH_SEEDING_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define XO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xoshiro assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define XO_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xoshiro assertion failed");
`else
`define XO_ASSERT_IMP(label, ante, cons)
`define XO_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* hdl/xoshiro_pkg.sv */
// Types and constants of the xoshiro256** generator.
package xoshiro_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int WORDS = 4;
  localparam int WIDX_W = $clog2(WORDS);
  localparam int ADV_ROUNDS = 8;
  localparam int ADV_CNT_W = $clog2(ADV_ROUNDS);

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D049BB133111EB;

  localparam int MIX_SH_A = 30;
  localparam int MIX_SH_B = 27;
  localparam int MIX_SH_C = 31;
  localparam int ADV_SHL = 17;
  localparam int ADV_ROT = 45;
  localparam int OUT_ROT = 7;

  // Request codes on req_type
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NXT_OUT,
    ST_SM_ADD,
    ST_MULA_GO,
    ST_MULA_WAIT,
    ST_MULB_GO,
    ST_MULB_WAIT,
    ST_ADV
  } core_state_t;

  // Top to core control
  typedef struct packed {
    logic start;
    logic req_next;
    logic out_free;
  } core_ctl_t;

  // Core to top status
  typedef struct packed {
    logic idle;
    logic res_load;
  } core_stat_t;

endpackage

/* hdl/xoshiro_mul.sv */
// Iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle.
module xoshiro_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [xoshiro_pkg::WORD_W-1:0]  a,
  input  logic [xoshiro_pkg::WORD_W-1:0]  b,
  output logic                            done,
  output logic [xoshiro_pkg::WORD_W-1:0]  prod
);

  logic                            run;
  logic [1:0]                      step;
  logic [xoshiro_pkg::WORD_W-1:0]  a_q;
  logic [xoshiro_pkg::WORD_W-1:0]  b_q;
  logic [xoshiro_pkg::HALF_W-1:0]  op_x;
  logic [xoshiro_pkg::HALF_W-1:0]  op_y;
  logic [xoshiro_pkg::WORD_W-1:0]  pp;
  logic [xoshiro_pkg::WORD_W-1:0]  pp_next;
  logic [xoshiro_pkg::WORD_W-1:0]  acc;
  logic [xoshiro_pkg::WORD_W-1:0]  pp_up;

  // Half-word operand pick: lo*lo, hi*lo, lo*hi
  always_comb begin
    unique case (step)
      2'd0: begin
        op_x = a_q[xoshiro_pkg::HALF_W-1:0];
        op_y = b_q[xoshiro_pkg::HALF_W-1:0];
      end
      2'd1: begin
        op_x = a_q[xoshiro_pkg::WORD_W-1:xoshiro_pkg::HALF_W];
        op_y = b_q[xoshiro_pkg::HALF_W-1:0];
      end
      2'd2: begin
        op_x = a_q[xoshiro_pkg::HALF_W-1:0];
        op_y = b_q[xoshiro_pkg::WORD_W-1:xoshiro_pkg::HALF_W];
      end
      default: begin
        op_x = a_q[xoshiro_pkg::HALF_W-1:0];
        op_y = b_q[xoshiro_pkg::HALF_W-1:0];
      end
    endcase
  end

  // Full 64-bit product of the two zero-extended halves
  assign pp_next = xoshiro_pkg::WORD_W'(op_x) * xoshiro_pkg::WORD_W'(op_y);
  assign pp_up = {pp[xoshiro_pkg::HALF_W-1:0], {xoshiro_pkg::HALF_W{1'b0}}};
  assign prod = acc;

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        step <= 2'd0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (run) begin
      pp <= pp_next;
      unique case (step)
        2'd0:    acc <= acc;
        2'd1:    acc <= pp;
        default: acc <= acc + pp_up;
      endcase
    end
  end

endmodule

/* hdl/xoshiro_core.sv */
// Generator state and sequencer: next-word path, splitmix64 fill and warm-up.
`include "xoshiro256ss_prng_with_seeding_top_macros.svh"

module xoshiro_core (
  input  logic                            clk,
  input  logic                            rst,
  input  xoshiro_pkg::core_ctl_t          ctl_i,
  input  logic [xoshiro_pkg::WORD_W-1:0]  seed_value,
  output xoshiro_pkg::core_stat_t         stat_o,
  output logic [xoshiro_pkg::WORD_W-1:0]  res_word
);

  xoshiro_pkg::core_state_t state;
  xoshiro_pkg::core_state_t state_next;

  logic [xoshiro_pkg::WORD_W-1:0]     s0, s1, s2, s3;
  logic [xoshiro_pkg::WORD_W-1:0]     n0, n1, n2, n3;
  logic [xoshiro_pkg::WORD_W-1:0]     t2, t3, sh;
  logic [xoshiro_pkg::WORD_W-1:0]     cnt;
  logic [xoshiro_pkg::WORD_W-1:0]     cnt_add;
  logic [xoshiro_pkg::WORD_W-1:0]     z;
  logic [xoshiro_pkg::WORD_W-1:0]     tmp;
  logic [xoshiro_pkg::WORD_W-1:0]     rot;
  logic [xoshiro_pkg::WORD_W-1:0]     fill_word;
  logic [xoshiro_pkg::WIDX_W-1:0]     widx;
  logic [xoshiro_pkg::ADV_CNT_W-1:0]  rnd;
  logic                               mul_start;
  logic                               mul_done;
  logic [xoshiro_pkg::WORD_W-1:0]     mul_b;
  logic [xoshiro_pkg::WORD_W-1:0]     mul_prod;
  logic                               last_word;
  logic                               last_rnd;
  logic                               seed_go;
  logic                               next_go;
  logic                               fill_done;

  // One xoshiro256 state step
  always_comb begin
    sh = s1 << xoshiro_pkg::ADV_SHL;
    t2 = s2 ^ s0;
    t3 = s3 ^ s1;
    n1 = s1 ^ t2;
    n0 = s0 ^ t3;
    n2 = t2 ^ sh;
    n3 = (t3 << xoshiro_pkg::ADV_ROT) | (t3 >> (xoshiro_pkg::WORD_W - xoshiro_pkg::ADV_ROT));
  end

  // Output scrambler second half: rotl(s1*5, 7) * 9, tmp holds s1*5
  assign rot = (tmp << xoshiro_pkg::OUT_ROT) |
               (tmp >> (xoshiro_pkg::WORD_W - xoshiro_pkg::OUT_ROT));
  assign res_word = rot + (rot << 3);

  assign cnt_add = cnt + xoshiro_pkg::GOLDEN_GAMMA;
  assign fill_word = mul_prod ^ (mul_prod >> xoshiro_pkg::MIX_SH_C);
  assign last_word = (widx == xoshiro_pkg::WIDX_W'(xoshiro_pkg::WORDS - 1));
  assign last_rnd = (rnd == xoshiro_pkg::ADV_CNT_W'(xoshiro_pkg::ADV_ROUNDS - 1));
  assign mul_b = (state == xoshiro_pkg::ST_MULB_GO) ? xoshiro_pkg::MIX_MUL_B
                                                     : xoshiro_pkg::MIX_MUL_A;

  // Request taken in idle, and last product of a fill word
  assign seed_go = (state == xoshiro_pkg::ST_IDLE) && ctl_i.start && !ctl_i.req_next;
  assign next_go = (state == xoshiro_pkg::ST_IDLE) && ctl_i.start && ctl_i.req_next;
  assign fill_done = (state == xoshiro_pkg::ST_MULB_WAIT) && mul_done;

  // Shared multiplier for the splitmix64 products
  xoshiro_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (z),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      xoshiro_pkg::ST_IDLE: begin
        if (ctl_i.start) begin
          state_next = ctl_i.req_next ? xoshiro_pkg::ST_NXT_OUT : xoshiro_pkg::ST_SM_ADD;
        end
      end
      xoshiro_pkg::ST_NXT_OUT: begin
        if (ctl_i.out_free) begin
          state_next = xoshiro_pkg::ST_IDLE;
        end
      end
      xoshiro_pkg::ST_SM_ADD:  state_next = xoshiro_pkg::ST_MULA_GO;
      xoshiro_pkg::ST_MULA_GO: state_next = xoshiro_pkg::ST_MULA_WAIT;
      xoshiro_pkg::ST_MULA_WAIT: begin
        if (mul_done) begin
          state_next = xoshiro_pkg::ST_MULB_GO;
        end
      end
      xoshiro_pkg::ST_MULB_GO: state_next = xoshiro_pkg::ST_MULB_WAIT;
      xoshiro_pkg::ST_MULB_WAIT: begin
        if (mul_done) begin
          state_next = last_word ? xoshiro_pkg::ST_ADV : xoshiro_pkg::ST_SM_ADD;
        end
      end
      xoshiro_pkg::ST_ADV: begin
        if (last_rnd) begin
          state_next = xoshiro_pkg::ST_IDLE;
        end
      end
      default: state_next = xoshiro_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mul_start = (state == xoshiro_pkg::ST_MULA_GO) || (state == xoshiro_pkg::ST_MULB_GO);
    stat_o.idle = (state == xoshiro_pkg::ST_IDLE);
    stat_o.res_load = (state == xoshiro_pkg::ST_NXT_OUT) && ctl_i.out_free;
  end

  // State register and generator words
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xoshiro_pkg::ST_IDLE;
      s0 <= '0;
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (next_go || state == xoshiro_pkg::ST_ADV) begin
        s0 <= n0;
        s1 <= n1;
        s2 <= n2;
        s3 <= n3;
      end else if (fill_done) begin
        unique case (widx)
          2'd0:    s0 <= fill_word;
          2'd1:    s1 <= fill_word;
          2'd2:    s2 <= fill_word;
          default: s3 <= fill_word;
        endcase
      end
      if (seed_go) begin
        cnt <= (seed_value == '0) ? xoshiro_pkg::GOLDEN_GAMMA : seed_value;
      end else if (state == xoshiro_pkg::ST_SM_ADD) begin
        cnt <= cnt_add;
      end
    end
  end

  // Datapath scratch registers
  always_ff @(posedge clk) begin
    unique case (state)
      xoshiro_pkg::ST_IDLE: begin
        tmp <= s1 + (s1 << 2);
        widx <= '0;
        rnd <= '0;
      end
      xoshiro_pkg::ST_SM_ADD: begin
        z <= cnt_add ^ (cnt_add >> xoshiro_pkg::MIX_SH_A);
      end
      xoshiro_pkg::ST_MULA_WAIT: begin
        if (mul_done) begin
          z <= mul_prod ^ (mul_prod >> xoshiro_pkg::MIX_SH_B);
        end
      end
      xoshiro_pkg::ST_MULB_WAIT: begin
        if (mul_done) begin
          widx <= widx + xoshiro_pkg::WIDX_W'(1);
        end
      end
      xoshiro_pkg::ST_ADV: begin
        rnd <= rnd + xoshiro_pkg::ADV_CNT_W'(1);
      end
      default: begin
        z <= z;
      end
    endcase
  end

  `XO_ASSERT_IMP(a_done_in_wait, mul_done, state == xoshiro_pkg::ST_MULA_WAIT || fill_done)
  `XO_ASSERT_NXT(a_seed_starts_fill, seed_go, state == xoshiro_pkg::ST_SM_ADD)
  `XO_ASSERT_NXT(a_load_to_idle, stat_o.res_load, state == xoshiro_pkg::ST_IDLE)

endmodule

/* hdl/xoshiro256ss_prng_with_seeding_top.sv */
// Top level of the xoshiro256** generator with splitmix64 seeding.
//
// Input channel (in_valid/in_ready, req_type, seed_value): one word per request.
// req_type 0 seeds the generator from seed_value (zero seed uses the golden-ratio
// constant); req_type 1 asks for the next 64-bit random word.
// Output channel (out_valid/out_ready, random_word): one word per next request,
// none per seed request.
// Next request: accepted, state steps at once, the word is formed in the
// following cycle and lands in the output register; a new request is taken
// only once that word has been loaded into the output register.
// Seed request: after acceptance the core is busy with four splitmix64
// words, each through two products on the shared 32x32 multiplier, then
// eight state steps, one per cycle.
// in_ready is high only while the sequencer is idle.
// Reset clears the state to zero, so next words read zero until seeded.
// A stalled receiver holds the word in the output register; one more next
// request may be taken and then waits inside the core until the register frees.
module xoshiro256ss_prng_with_seeding_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [xoshiro_pkg::WORD_W-1:0]  seed_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xoshiro_pkg::WORD_W-1:0]  random_word
);

  xoshiro_pkg::core_ctl_t           ctl;
  xoshiro_pkg::core_stat_t          stat;
  logic [xoshiro_pkg::WORD_W-1:0]   res_word;

  // Handshake toward the core
  assign in_ready = stat.idle;
  assign ctl.start = in_valid && in_ready;
  assign ctl.req_next = (req_type == xoshiro_pkg::REQ_NEXT);
  assign ctl.out_free = !out_valid || out_ready;

  xoshiro_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl_i      (ctl),
    .seed_value (seed_value),
    .stat_o     (stat),
    .res_word   (res_word)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_load) begin
      random_word <= res_word;
    end
  end

endmodule

/* tb/xoshiro_stream_check.sv */
// Watches both channels of the xoshiro256** generator, predicts each random word and compares.
`timescale 1ns / 100ps

module xoshiro_stream_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           req_type,
  input  logic [xoshiro_pkg::WORD_W-1:0] seed_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [xoshiro_pkg::WORD_W-1:0] random_word,
  output int                             fail_count,
  output int                             pending_words
);

  // Predicted generator state
  logic [xoshiro_pkg::WORD_W-1:0] gen_state [xoshiro_pkg::WORDS];
  logic [xoshiro_pkg::WORD_W-1:0] mix_ctr;
  logic [xoshiro_pkg::WORD_W-1:0] expected_words [$];

  initial begin
    fail_count = 0;
    pending_words = 0;
  end

  function automatic logic [xoshiro_pkg::WORD_W-1:0] rotl(
    input logic [xoshiro_pkg::WORD_W-1:0] v,
    input int r
  );
    return (v << r) | (v >> (xoshiro_pkg::WORD_W - r));
  endfunction

  // One splitmix64 draw; advances the mix counter
  function automatic logic [xoshiro_pkg::WORD_W-1:0] mix_draw();
    logic [xoshiro_pkg::WORD_W-1:0] z;
    mix_ctr = mix_ctr + xoshiro_pkg::GOLDEN_GAMMA;
    z = mix_ctr;
    z = (z ^ (z >> xoshiro_pkg::MIX_SH_A)) * xoshiro_pkg::MIX_MUL_A;
    z = (z ^ (z >> xoshiro_pkg::MIX_SH_B)) * xoshiro_pkg::MIX_MUL_B;
    return z ^ (z >> xoshiro_pkg::MIX_SH_C);
  endfunction

  // One xoshiro256** step; returns the scrambled word
  function automatic logic [xoshiro_pkg::WORD_W-1:0] step_state();
    logic [xoshiro_pkg::WORD_W-1:0] word;
    logic [xoshiro_pkg::WORD_W-1:0] times5;
    logic [xoshiro_pkg::WORD_W-1:0] shl;
    times5 = gen_state[1] * 64'd5;
    word = rotl(times5, xoshiro_pkg::OUT_ROT) * 64'd9;
    shl = gen_state[1] << xoshiro_pkg::ADV_SHL;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ shl;
    gen_state[3] = rotl(gen_state[3], xoshiro_pkg::ADV_ROT);
    return word;
  endfunction

  always @(posedge clk) begin
    logic [xoshiro_pkg::WORD_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < xoshiro_pkg::WORDS; i++) gen_state[i] = '0;
      mix_ctr = '0;
      expected_words.delete();
    end else begin
      // Output side first: a word leaving now never belongs to a request taken now
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: random_word expected none, got %h", $time, random_word);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            $display("%0t: random_word expected %h, got %h", $time, want, random_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Input side: seed reloads the state, next yields one word
      if (in_valid && in_ready) begin
        if (req_type == xoshiro_pkg::REQ_NEXT) begin
          expected_words.push_back(step_state());
        end else begin
          mix_ctr = (seed_value == '0) ? xoshiro_pkg::GOLDEN_GAMMA : seed_value;
          for (int i = 0; i < xoshiro_pkg::WORDS; i++) gen_state[i] = mix_draw();
          for (int i = 0; i < xoshiro_pkg::ADV_ROUNDS; i++) void'(step_state());
        end
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

/* tb/xoshiro256ss_prng_with_seeding_top_test.sv */
// Stimulus and verdict for the xoshiro256** generator with splitmix64 seeding.
`timescale 1ns / 100ps

module xoshiro256ss_prng_with_seeding_top_test;

  localparam int RANDOM_ITEMS = 630;
  localparam int HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           req_type = xoshiro_pkg::REQ_NEXT;
  logic [xoshiro_pkg::WORD_W-1:0] seed_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [xoshiro_pkg::WORD_W-1:0] random_word;
  logic                           calm = 1'b0;
  logic                           hold_req = 1'b0;
  int                             fail_count;
  int                             pending_words;

  xoshiro256ss_prng_with_seeding_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .seed_value(seed_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .random_word(random_word)
  );

  xoshiro_stream_check mon (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .seed_value(seed_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .random_word(random_word),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop
  initial begin
    #4000000;
    $display("xoshiro256ss_prng_with_seeding_top: mismatch");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    logic hold_prev;
    hold_prev = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_prev) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 22);
      end
      hold_prev = hold_req;
    end
  end

  // Offer one word and return at the edge that takes it
  task automatic send_item(input logic kind, input logic [xoshiro_pkg::WORD_W-1:0] seed);
    in_valid <= 1'b1;
    req_type <= kind;
    seed_value <= seed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop offering until every predicted word has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  function automatic logic [xoshiro_pkg::WORD_W-1:0] pick_seed();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(xoshiro_pkg::WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: unseeded zeros, zero seed, extreme seeds, seed field ignored on next
    send_item(xoshiro_pkg::REQ_NEXT, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '1);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '1);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, '1);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, 64'h5555555555555555);   maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, 64'd1);                  maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, 64'hAAAAAAAAAAAAAAAA);   maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, 64'h8000000000000000);   maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, xoshiro_pkg::GOLDEN_GAMMA); maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '0);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, 64'h5555555555555555);   maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '1);                     maybe_gap();
    send_item(xoshiro_pkg::REQ_SEED, 64'hAAAAAAAAAAAAAAAA);   maybe_gap();
    send_item(xoshiro_pkg::REQ_NEXT, '0);
    send_item(xoshiro_pkg::REQ_NEXT, '0);
    send_item(xoshiro_pkg::REQ_NEXT, '0);
    drain();

    // Random part, mostly next requests with the odd reseed
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 400 && n < 520);
      if (n == 150) begin
        // Long output stall while requests keep coming: block fills and stops taking input
        hold_req <= 1'b1;
        for (int k = 0; k < 12; k++) send_item(xoshiro_pkg::REQ_NEXT, {$urandom, $urandom});
        drain();
      end
      if (n == 300) drain();
      kind = ($urandom_range(99) < 12) ? xoshiro_pkg::REQ_SEED : xoshiro_pkg::REQ_NEXT;
      send_item(kind, (kind == xoshiro_pkg::REQ_SEED) ? pick_seed() : {$urandom, $urandom});
      if (n != RANDOM_ITEMS - 1) maybe_gap();
    end
    drain();
    repeat (80) @(posedge clk);

    if (fail_count == 0) begin
      $display("xoshiro256ss_prng_with_seeding_top: match");
    end else begin
      $display("xoshiro256ss_prng_with_seeding_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/xoshiro_pkg.sv
hdl/xoshiro_mul.sv
hdl/xoshiro_core.sv
hdl/xoshiro256ss_prng_with_seeding_top.sv
tb/xoshiro_stream_check.sv
tb/xoshiro256ss_prng_with_seeding_top_test.sv
